>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ftgc_pkg.sv
// Types, constants and register codes of the gravity compensation block.
package ftgc_pkg;

   // Default width of the stored offsets and of the saturation point.
   localparam int DATA_WIDTH_DEF = 32;

   // Field widths.
   localparam int DIR_W  = 16;
   localparam int MEAS_W = 32;
   localparam int MASS_W = 24;
   localparam int CENT_W = 19;

   // Register port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_PAYLOAD_MASS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTROID_X   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTROID_Y   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTROID_Z   = 2'd3;

   // Shared multiplier and accumulator widths.
   localparam int OPA_W  = 30;
   localparam int OPB_W  = 22;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int ACC_W  = 64;

   // Cross product width, and the split of it into a high and a low part.
   localparam int C_W  = 36;
   localparam int CL_W = 18;

   // Width of a predicted force or torque.
   localparam int PRED_W = 34;

   // Rounding shifts of the weight, the force and the torque.
   localparam int W_SHIFT = 16;
   localparam int F_SHIFT = 14;
   localparam int T_SHIFT = 30;
   localparam logic signed [ACC_W-1:0] RND_W = ACC_W'(1) <<< (W_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] RND_F = ACC_W'(1) <<< (F_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] RND_T = ACC_W'(1) <<< (T_SHIFT - 1);

   // Gravity in Q.16 metres per second squared.
   localparam logic signed [OPB_W-1:0] G_Q16 = -22'sd642689;

   // Sequencer.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

   // Accumulator control for the product of the previous cycle.
   typedef struct packed {
      logic acc_en;
      logic acc_clr;
      logic acc_sub;
      logic acc_shl;
   } mac_ctl_type;

   // One input word.
   typedef struct packed {
      logic                     pose_valid;
      logic signed [DIR_W-1:0]  down_dir_x;
      logic signed [DIR_W-1:0]  down_dir_y;
      logic signed [DIR_W-1:0]  down_dir_z;
      logic signed [MEAS_W-1:0] meas_force_x;
      logic signed [MEAS_W-1:0] meas_force_y;
      logic signed [MEAS_W-1:0] meas_force_z;
      logic signed [MEAS_W-1:0] meas_torque_x;
      logic signed [MEAS_W-1:0] meas_torque_y;
      logic signed [MEAS_W-1:0] meas_torque_z;
   } req_type;

   // One result word.
   typedef struct packed {
      logic signed [MEAS_W-1:0] comp_force_x;
      logic signed [MEAS_W-1:0] comp_force_y;
      logic signed [MEAS_W-1:0] comp_force_z;
      logic signed [MEAS_W-1:0] comp_torque_x;
      logic signed [MEAS_W-1:0] comp_torque_y;
      logic signed [MEAS_W-1:0] comp_torque_z;
   } rsp_type;

endpackage

>>> hw/rtl/ft_sensor_gravity_compensation_unit.sv
// A word with a valid pose passes through the run state, the capture state for the first such word, and the
// result state into the output register; words without a pose go at one per cycle and give no result.
// The run state passes sixteen products in turn through one 30 x 22 bit multiplier; req_ready is low until idle.
// A finished result waits in the output register while the next word is taken and worked on.
// Reset is synchronous: it clears the registers, the offset capture flag and the result valid.
module ft_sensor_gravity_compensation_unit #(
   parameter int DATA_WIDTH = ftgc_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ftgc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ftgc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [ftgc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ftgc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SUM_W = ((DATA_WIDTH > ftgc_pkg::PRED_W) ? DATA_WIDTH : ftgc_pkg::PRED_W) + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_CAPTURE,
      S_RESULT
   } state_type;

   typedef enum logic [2:0] {
      D_NONE,
      D_W,
      D_C,
      D_PF,
      D_PT
   } dest_type;

   // Measured minus offset minus prediction, saturated to the offset width.
   function automatic logic signed [DATA_WIDTH-1:0] lane_sat(
      input logic signed [ftgc_pkg::MEAS_W-1:0] meas,
      input logic signed [DATA_WIDTH-1:0]       off,
      input logic signed [ftgc_pkg::PRED_W-1:0] pred
   );
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(meas) - SUM_W'(off) - SUM_W'(pred);
      if (s > SAT_HI) begin
         lane_sat = SAT_HI[DATA_WIDTH-1:0];
      end else if (s < SAT_LO) begin
         lane_sat = SAT_LO[DATA_WIDTH-1:0];
      end else begin
         lane_sat = s[DATA_WIDTH-1:0];
      end
   endfunction

   // The low 32 bits of a saturated value, sign extended where it is narrower.
   function automatic logic signed [ftgc_pkg::MEAS_W-1:0] to_field(
      input logic signed [DATA_WIDTH-1:0] v
   );
      logic signed [SUM_W-1:0] t;
      t = SUM_W'(v);
      to_field = t[ftgc_pkg::MEAS_W-1:0];
   endfunction

   state_type                               state_ff;
   logic [ftgc_pkg::STEP_W-1:0]             step_ff;
   logic                                    captured_ff;
   ftgc_pkg::req_type                       item_ff;
   logic [ftgc_pkg::MASS_W-1:0]             mass_ff;
   logic signed [ftgc_pkg::CENT_W-1:0]      cx_ff;
   logic signed [ftgc_pkg::CENT_W-1:0]      cy_ff;
   logic signed [ftgc_pkg::CENT_W-1:0]      cz_ff;
   logic signed [ftgc_pkg::OPA_W-1:0]       w_ff;
   logic signed [ftgc_pkg::C_W-1:0]         c_ff [3];
   logic signed [ftgc_pkg::PRED_W-1:0]      pf_ff [3];
   logic signed [ftgc_pkg::PRED_W-1:0]      pt_ff [3];
   logic signed [DATA_WIDTH-1:0]            off_f_ff [3];
   logic signed [DATA_WIDTH-1:0]            off_t_ff [3];
   logic                                    rsp_valid_ff;
   ftgc_pkg::rsp_type                       rsp_data_ff;

   logic signed [ftgc_pkg::OPA_W-1:0]       op_a;
   logic signed [ftgc_pkg::OPB_W-1:0]       op_b;
   ftgc_pkg::mac_ctl_type                   mac_ctl;
   ftgc_pkg::mac_ctl_type                   mac_ctl_run;
   dest_type                                dest;
   logic [1:0]                              dest_idx;
   logic signed [ftgc_pkg::ACC_W-1:0]       acc_next;
   logic signed [ftgc_pkg::ACC_W-1:0]       w_sum;
   logic signed [ftgc_pkg::ACC_W-1:0]       pf_sum;
   logic signed [ftgc_pkg::ACC_W-1:0]       pt_sum;
   logic signed [ftgc_pkg::OPA_W-1:0]       w_in;
   logic signed [ftgc_pkg::PRED_W-1:0]      pf_in;
   logic signed [ftgc_pkg::PRED_W-1:0]      pt_in;
   logic signed [ftgc_pkg::MEAS_W-1:0]      mf [3];
   logic signed [ftgc_pkg::MEAS_W-1:0]      mt [3];
   logic signed [DATA_WIDTH-1:0]            off_f_in [3];
   logic signed [DATA_WIDTH-1:0]            off_t_in [3];
   logic signed [DATA_WIDTH-1:0]            res_f [3];
   logic signed [DATA_WIDTH-1:0]            res_t [3];
   ftgc_pkg::rsp_type                       rsp_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Schedule of the shared unit: operands issued this step, and what to do with the
   // product issued the step before.
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      mac_ctl  = '0;
      dest     = D_NONE;
      dest_idx = 2'd0;
      case (step_ff)
         5'd0: begin
            op_a = ftgc_pkg::OPA_W'(mass_ff);
            op_b = ftgc_pkg::G_Q16;
         end
         5'd1: begin
            op_a    = ftgc_pkg::OPA_W'(cy_ff);
            op_b    = ftgc_pkg::OPB_W'(item_ff.down_dir_z);
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
            dest    = D_W;
         end
         5'd2: begin
            op_a    = ftgc_pkg::OPA_W'(cz_ff);
            op_b    = ftgc_pkg::OPB_W'(item_ff.down_dir_y);
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
         end
         5'd3: begin
            op_a     = ftgc_pkg::OPA_W'(cz_ff);
            op_b     = ftgc_pkg::OPB_W'(item_ff.down_dir_x);
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b1, acc_shl: 1'b0};
            dest     = D_C;
            dest_idx = 2'd0;
         end
         5'd4: begin
            op_a    = ftgc_pkg::OPA_W'(cx_ff);
            op_b    = ftgc_pkg::OPB_W'(item_ff.down_dir_z);
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
         end
         5'd5: begin
            op_a     = ftgc_pkg::OPA_W'(cx_ff);
            op_b     = ftgc_pkg::OPB_W'(item_ff.down_dir_y);
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b1, acc_shl: 1'b0};
            dest     = D_C;
            dest_idx = 2'd1;
         end
         5'd6: begin
            op_a    = ftgc_pkg::OPA_W'(cy_ff);
            op_b    = ftgc_pkg::OPB_W'(item_ff.down_dir_x);
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
         end
         5'd7: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(item_ff.down_dir_x);
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b1, acc_shl: 1'b0};
            dest     = D_C;
            dest_idx = 2'd2;
         end
         5'd8: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(item_ff.down_dir_y);
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PF;
            dest_idx = 2'd0;
         end
         5'd9: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(item_ff.down_dir_z);
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PF;
            dest_idx = 2'd1;
         end
         5'd10: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(signed'(c_ff[0][ftgc_pkg::C_W-1:ftgc_pkg::CL_W]));
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PF;
            dest_idx = 2'd2;
         end
         5'd11: begin
            op_a    = w_ff;
            op_b    = ftgc_pkg::OPB_W'({1'b0, c_ff[0][ftgc_pkg::CL_W-1:0]});
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b1};
         end
         5'd12: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(signed'(c_ff[1][ftgc_pkg::C_W-1:ftgc_pkg::CL_W]));
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PT;
            dest_idx = 2'd0;
         end
         5'd13: begin
            op_a    = w_ff;
            op_b    = ftgc_pkg::OPB_W'({1'b0, c_ff[1][ftgc_pkg::CL_W-1:0]});
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b1};
         end
         5'd14: begin
            op_a     = w_ff;
            op_b     = ftgc_pkg::OPB_W'(signed'(c_ff[2][ftgc_pkg::C_W-1:ftgc_pkg::CL_W]));
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PT;
            dest_idx = 2'd1;
         end
         5'd15: begin
            op_a    = w_ff;
            op_b    = ftgc_pkg::OPB_W'({1'b0, c_ff[2][ftgc_pkg::CL_W-1:0]});
            mac_ctl = '{acc_en: 1'b1, acc_clr: 1'b1, acc_sub: 1'b0, acc_shl: 1'b1};
         end
         5'd16: begin
            mac_ctl  = '{acc_en: 1'b1, acc_clr: 1'b0, acc_sub: 1'b0, acc_shl: 1'b0};
            dest     = D_PT;
            dest_idx = 2'd2;
         end
         default: begin
            dest = D_NONE;
         end
      endcase
   end

   // The accumulator only moves while a word is being worked on.
   assign mac_ctl_run = (state_ff == S_RUN) ? mac_ctl : '0;

   ftgc_mac u_mac (
      .clock    (clock),
      .op_a     (op_a),
      .op_b     (op_b),
      .ctl      (mac_ctl_run),
      .acc_next (acc_next)
   );

   // Round half up of the accumulator for the weight, the forces and the torques.
   always_comb begin
      w_sum  = (acc_next + ftgc_pkg::RND_W) >>> ftgc_pkg::W_SHIFT;
      pf_sum = (acc_next + ftgc_pkg::RND_F) >>> ftgc_pkg::F_SHIFT;
      pt_sum = (acc_next + ftgc_pkg::RND_T) >>> ftgc_pkg::T_SHIFT;
      w_in   = w_sum[ftgc_pkg::OPA_W-1:0];
      pf_in  = pf_sum[ftgc_pkg::PRED_W-1:0];
      pt_in  = pt_sum[ftgc_pkg::PRED_W-1:0];
   end

   // Offset capture and result lanes, one for each force and torque axis.
   always_comb begin
      mf[0] = item_ff.meas_force_x;
      mf[1] = item_ff.meas_force_y;
      mf[2] = item_ff.meas_force_z;
      mt[0] = item_ff.meas_torque_x;
      mt[1] = item_ff.meas_torque_y;
      mt[2] = item_ff.meas_torque_z;
      for (int i = 0; i < 3; i++) begin
         off_f_in[i] = lane_sat(mf[i], '0, pf_ff[i]);
         off_t_in[i] = lane_sat(mt[i], '0, pt_ff[i]);
         res_f[i]    = lane_sat(mf[i], off_f_ff[i], pf_ff[i]);
         res_t[i]    = lane_sat(mt[i], off_t_ff[i], pt_ff[i]);
      end
      rsp_in.comp_force_x  = to_field(res_f[0]);
      rsp_in.comp_force_y  = to_field(res_f[1]);
      rsp_in.comp_force_z  = to_field(res_f[2]);
      rsp_in.comp_torque_x = to_field(res_t[0]);
      rsp_in.comp_torque_y = to_field(res_t[1]);
      rsp_in.comp_torque_z = to_field(res_t[2]);
   end

   // Sequencer, registers, working values and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         captured_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mass_ff      <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ftgc_pkg::REG_PAYLOAD_MASS: mass_ff <= csr_wdata;
               ftgc_pkg::REG_CENTROID_X:   cx_ff   <= csr_wdata[ftgc_pkg::CENT_W-1:0];
               ftgc_pkg::REG_CENTROID_Y:   cy_ff   <= csr_wdata[ftgc_pkg::CENT_W-1:0];
               ftgc_pkg::REG_CENTROID_Z:   cz_ff   <= csr_wdata[ftgc_pkg::CENT_W-1:0];
               default: begin
               end
            endcase
         end

         // The result state refills the output register itself when the old word leaves.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  step_ff <= '0;
                  if (req_data.pose_valid) begin
                     state_ff <= S_RUN;
                  end
               end
            end
            S_RUN: begin
               step_ff <= step_ff + 1'b1;
               case (dest)
                  D_W:     w_ff <= w_in;
                  D_C:     c_ff[dest_idx] <= acc_next[ftgc_pkg::C_W-1:0];
                  D_PF:    pf_ff[dest_idx] <= pf_in;
                  D_PT:    pt_ff[dest_idx] <= pt_in;
                  default: begin
                  end
               endcase
               if (step_ff == ftgc_pkg::LAST_STEP) begin
                  state_ff <= captured_ff ? S_RESULT : S_CAPTURE;
               end
            end
            S_CAPTURE: begin
               off_f_ff    <= off_f_in;
               off_t_ff    <= off_t_in;
               captured_ff <= 1'b1;
               state_ff    <= S_RESULT;
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/ftgc_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
module ftgc_mac (
   input  logic                                   clock,
   input  logic signed [ftgc_pkg::OPA_W-1:0]      op_a,
   input  logic signed [ftgc_pkg::OPB_W-1:0]      op_b,
   input  ftgc_pkg::mac_ctl_type                  ctl,
   output logic signed [ftgc_pkg::ACC_W-1:0]      acc_next
);

   logic signed [ftgc_pkg::PROD_W-1:0] prod_ff;
   logic signed [ftgc_pkg::ACC_W-1:0]  acc_ff;
   logic signed [ftgc_pkg::ACC_W-1:0]  prod_ext;
   logic signed [ftgc_pkg::ACC_W-1:0]  addend;
   logic signed [ftgc_pkg::ACC_W-1:0]  base;

   // The product of the previous cycle, optionally moved up by the low-part width.
   always_comb begin
      prod_ext = ftgc_pkg::ACC_W'(prod_ff);
      addend   = ctl.acc_shl ? (prod_ext <<< ftgc_pkg::CL_W) : prod_ext;
      base     = ctl.acc_clr ? '0 : acc_ff;
      acc_next = ctl.acc_sub ? (base - addend) : (base + addend);
   end

   // Multiply every cycle; the accumulator only moves when told to.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctl.acc_en) begin
         acc_ff <= acc_next;
      end
   end

endmodule

>>> hw/rtl/ftgc_checker.sv
// Port checker of the gravity compensation block and its bind to the top level.
`include "assert_macros.svh"

module ftgc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ftgc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ftgc_pkg::rsp_type rsp_data
);

   // A stalled result word stays offered and unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "result word changed while stalled")

   // A sample with a known pose keeps the block busy.
   `ASSERT_NEXT(a_busy_after_sample, clock, reset, req_valid && req_ready && req_data.pose_valid, !req_ready, "block took a word while computing")

   // A sample without a pose produces nothing.
   `ASSERT_NEXT(a_drop_silent, clock, reset, req_valid && req_ready && !req_data.pose_valid && !rsp_valid, !rsp_valid, "result appeared for a dropped sample")

   // A result only appears at the end of a computation.
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "result appeared without a computation")

endmodule

bind ft_sensor_gravity_compensation_unit ftgc_checker u_ftgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/ft_sensor_gravity_compensation_unit_test.sv
// Self-checking testbench for the force/torque gravity compensation unit.
`timescale 1ns / 100ps

module ft_sensor_gravity_compensation_unit_test;

   // Cycles to let pass once the last result is in, before touching the registers.
   localparam int SETTLE_CYCLES   = 25;
   // Cycles without any accepted word or register write before the run is declared hung.
   localparam int STALL_LIMIT     = 4000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int MAX_REPORTS     = 10;

   // Gravity in Q.16 metres per second squared.
   localparam logic signed [63:0] GRAVITY_Q16 = -64'sd642689;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ftgc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ftgc_pkg::rsp_type rsp_data;
   logic                            csr_we    = 1'b0;
   logic [ftgc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ftgc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Mirror of the block's registers and offset state.
   logic        [ftgc_pkg::MASS_W-1:0] mass_q16;
   logic signed [ftgc_pkg::CENT_W-1:0] cent_x;
   logic signed [ftgc_pkg::CENT_W-1:0] cent_y;
   logic signed [ftgc_pkg::CENT_W-1:0] cent_z;
   logic signed [63:0]                 force_ofs [3];
   logic signed [63:0]                 torque_ofs [3];
   bit                                 offset_held;

   // Compensated words still to come out of the block, oldest first.
   ftgc_pkg::rsp_type comp_expected [$];

   bit sender_gaps     = 1'b1;
   bit receiver_stalls = 1'b1;
   int stall_left      = 0;
   int idle_cycles     = 0;

   int words_sent    = 0;
   int posed_sent    = 0;
   int results_seen  = 0;
   int settings_used = 0;
   int fail_count    = 0;

   string field_name [6] = '{"comp_force_x", "comp_force_y", "comp_force_z",
                             "comp_torque_x", "comp_torque_y", "comp_torque_z"};

   ft_sensor_gravity_compensation_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Divide by a power of two, rounding half up.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Clamp to the signed range of the stored offsets.
   function automatic logic signed [63:0] clamp_data(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (ftgc_pkg::DATA_WIDTH_DEF - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Works out the compensated word for one accepted sample and queues it.
   task automatic predict_compensation(input ftgc_pkg::req_type w);
      logic signed [63:0] dir [3];
      logic signed [63:0] mf [3];
      logic signed [63:0] mt [3];
      logic signed [63:0] arm [3];
      logic signed [63:0] pf [3];
      logic signed [63:0] pt [3];
      logic signed [63:0] weight, cx, cy, cz, f, t;
      ftgc_pkg::rsp_type r;
      if (!w.pose_valid) return;
      dir[0] = $signed(w.down_dir_x);
      dir[1] = $signed(w.down_dir_y);
      dir[2] = $signed(w.down_dir_z);
      mf[0] = $signed(w.meas_force_x);
      mf[1] = $signed(w.meas_force_y);
      mf[2] = $signed(w.meas_force_z);
      mt[0] = $signed(w.meas_torque_x);
      mt[1] = $signed(w.meas_torque_y);
      mt[2] = $signed(w.meas_torque_z);
      cx = cent_x;
      cy = cent_y;
      cz = cent_z;
      weight = round_shift($signed({40'd0, mass_q16}) * GRAVITY_Q16, 16);
      // Lever arm crossed with the gravity direction, kept exact in Q.30.
      arm[0] = cy * dir[2] - cz * dir[1];
      arm[1] = cz * dir[0] - cx * dir[2];
      arm[2] = cx * dir[1] - cy * dir[0];
      for (int i = 0; i < 3; i++) begin
         pf[i] = round_shift(weight * dir[i], 14);
         pt[i] = round_shift(weight * arm[i], 30);
      end
      // The first posed sample fixes the sensor offset for the rest of the run.
      if (!offset_held) begin
         for (int i = 0; i < 3; i++) begin
            force_ofs[i]  = clamp_data(mf[i] - pf[i]);
            torque_ofs[i] = clamp_data(mt[i] - pt[i]);
         end
         offset_held = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         f = clamp_data(mf[i] - force_ofs[i] - pf[i]);
         t = clamp_data(mt[i] - torque_ofs[i] - pt[i]);
         r[191 - 32 * i -: 32] = f[31:0];
         r[95 - 32 * i -: 32]  = t[31:0];
      end
      comp_expected.push_back(r);
   endtask

   // Offers one word, waits for it to be taken and records what it should give.
   // Valid is left high so that the next word can follow without a gap.
   task automatic send_word(input ftgc_pkg::req_type w);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (w.pose_valid) posed_sent++;
      predict_compensation(w);
   endtask

   // Lets every outstanding result drain and the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (comp_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; only called while the block is idle.
   task automatic write_registers(input logic [ftgc_pkg::CSR_DATA_W-1:0] mass_raw,
                                  input logic [ftgc_pkg::CSR_DATA_W-1:0] cx_raw,
                                  input logic [ftgc_pkg::CSR_DATA_W-1:0] cy_raw,
                                  input logic [ftgc_pkg::CSR_DATA_W-1:0] cz_raw);
      csr_we    <= 1'b1;
      csr_index <= ftgc_pkg::REG_PAYLOAD_MASS;
      csr_wdata <= mass_raw;
      @(posedge clock);
      csr_index <= ftgc_pkg::REG_CENTROID_X;
      csr_wdata <= cx_raw;
      @(posedge clock);
      csr_index <= ftgc_pkg::REG_CENTROID_Y;
      csr_wdata <= cy_raw;
      @(posedge clock);
      csr_index <= ftgc_pkg::REG_CENTROID_Z;
      csr_wdata <= cz_raw;
      @(posedge clock);
      csr_we <= 1'b0;
      mass_q16 = mass_raw[ftgc_pkg::MASS_W-1:0];
      cent_x   = cx_raw[ftgc_pkg::CENT_W-1:0];
      cent_y   = cy_raw[ftgc_pkg::CENT_W-1:0];
      cent_z   = cz_raw[ftgc_pkg::CENT_W-1:0];
      settings_used++;
   endtask

   function automatic logic [ftgc_pkg::CSR_DATA_W-1:0] random_mass();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 24'hFF_FFFF;
         2, 3: return 24'($urandom_range(0, 24'h0A_0000));
         default: return 24'($urandom());
      endcase
   endfunction

   // The bits above the centroid width are junk that the block must ignore.
   function automatic logic [ftgc_pkg::CSR_DATA_W-1:0] random_centroid();
      logic [ftgc_pkg::CENT_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 19'h4_0000;
         1: v = 19'h3_FFFF;
         2: v = '0;
         3, 4: v = 19'($urandom_range(0, 26214) - 13107);
         default: v = 19'($urandom());
      endcase
      return {5'($urandom()), v};
   endfunction

   function automatic logic [ftgc_pkg::DIR_W-1:0] random_dir();
      case ($urandom_range(0, 9))
         0, 1: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
         2: return '0;
         3, 4: return 16'($urandom());
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [ftgc_pkg::MEAS_W-1:0] random_meas();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   function automatic ftgc_pkg::req_type random_word();
      ftgc_pkg::req_type w;
      w.pose_valid    = ($urandom_range(0, 7) != 0);
      w.down_dir_x    = random_dir();
      w.down_dir_y    = random_dir();
      w.down_dir_z    = random_dir();
      w.meas_force_x  = random_meas();
      w.meas_force_y  = random_meas();
      w.meas_force_z  = random_meas();
      w.meas_torque_x = random_meas();
      w.meas_torque_y = random_meas();
      w.meas_torque_z = random_meas();
      return w;
   endfunction

   // Heavy payload at the far corners, a dropped sample first, then a capture
   // whose offset saturates in several axes.
   task automatic test_offset_capture();
      ftgc_pkg::req_type w;
      write_registers(24'hFF_FFFF, 24'h03_FFFF, 24'hFC_0000, 24'h00_0000);
      w = random_word();
      w.pose_valid = 1'b0;
      send_word(w);
      w.pose_valid    = 1'b1;
      w.down_dir_x    = 16'h4000;
      w.down_dir_y    = 16'hC000;
      w.down_dir_z    = 16'h4000;
      w.meas_force_x  = 32'h7FFF_FFFF;
      w.meas_force_y  = 32'h8000_0000;
      w.meas_force_z  = '0;
      w.meas_torque_x = 32'h8000_0000;
      w.meas_torque_y = 32'h8000_0000;
      w.meas_torque_z = 32'h7FFF_FFFF;
      send_word(w);
      send_word(w);
      w = random_word();
      w.pose_valid = 1'b1;
      send_word(w);
   endtask

   // Direction components and measurements at the limits of their fields.
   task automatic test_field_extremes();
      logic [ftgc_pkg::DIR_W-1:0]  dirs [6] =
         '{16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'h0000, 16'hFFFF};
      logic [ftgc_pkg::MEAS_W-1:0] meas [5] =
         '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
      ftgc_pkg::req_type w;
      for (int i = 0; i < 10; i++) begin
         w.pose_valid    = (i != 3) && (i != 7);
         w.down_dir_x    = dirs[i % 6];
         w.down_dir_y    = dirs[(i + 2) % 6];
         w.down_dir_z    = dirs[(i + 4) % 6];
         w.meas_force_x  = meas[i % 5];
         w.meas_force_y  = meas[(i + 1) % 5];
         w.meas_force_z  = meas[(i + 2) % 5];
         w.meas_torque_x = meas[(i + 3) % 5];
         w.meas_torque_y = meas[(i + 4) % 5];
         w.meas_torque_z = meas[(i + 2) % 5];
         send_word(w);
      end
   endtask

   // New mass and centroid after capture; the captured offset must stay.
   task automatic test_register_change();
      ftgc_pkg::req_type w;
      wait_idle();
      write_registers('0, '0, '0, '0);
      for (int i = 0; i < 3; i++) begin
         w = random_word();
         w.pose_valid = 1'b1;
         send_word(w);
      end
      wait_idle();
      write_registers(24'h00_0001, 24'hE3_FFFF, 24'h1C_0000, 24'h00_1000);
      for (int i = 0; i < 3; i++) begin
         w = random_word();
         w.pose_valid = 1'b1;
         send_word(w);
      end
   endtask

   // Random samples in phases, each under a fresh register setting; the last
   // phase runs with no idling on either side.
   task automatic test_random_samples();
      ftgc_pkg::req_type w;
      int posed_in_phase;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         sender_gaps     = (phase != 2) && (phase != RANDOM_PHASES - 1);
         receiver_stalls = (phase != 3) && (phase != RANDOM_PHASES - 1);
         write_registers(random_mass(), random_centroid(), random_centroid(), random_centroid());
         posed_in_phase = 0;
         while (posed_in_phase < ITEMS_PER_PHASE) begin
            w = random_word();
            send_word(w);
            if (w.pose_valid) posed_in_phase++;
         end
      end
   endtask

   // Result side: random stall bursts, and each accepted word checked
   // against the oldest prediction.
   always @(posedge clock) begin
      ftgc_pkg::rsp_type want;
      if (reset || !receiver_stalls) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 13) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (comp_expected.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("Result word %0d arrived with nothing expected: %h",
                        results_seen, rsp_data);
            fail_count++;
         end else begin
            want = comp_expected.pop_front();
            for (int k = 0; k < 6; k++) begin
               if (rsp_data[191 - 32 * k -: 32] !== want[191 - 32 * k -: 32]) begin
                  if (fail_count < MAX_REPORTS)
                     $display("Result word %0d, %s: expected %h, got %h", results_seen,
                              field_name[k], want[191 - 32 * k -: 32],
                              rsp_data[191 - 32 * k -: 32]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no word accepted for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mass_q16    = '0;
      cent_x      = '0;
      cent_y      = '0;
      cent_z      = '0;
      offset_held = 1'b0;
      for (int i = 0; i < 3; i++) begin
         force_ofs[i]  = '0;
         torque_ofs[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_offset_capture();
      test_field_extremes();
      test_register_change();
      test_random_samples();
      wait_idle();
      $display("Sent %0d words, %0d with a known pose; checked %0d compensated results",
               words_sent, posed_sent, results_seen);
      $display("over %0d register settings, including saturating offsets and extreme fields.",
               settings_used);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
